@@ hw/rtl/swpe_pkg.sv @@
// shared types, constants and register codes of the sliding-window patch extractor
package swpe_pkg;

   // default storage dimensions
   localparam int DEF_MAX_WIDTH  = 32;
   localparam int DEF_MAX_KERNEL = 7;

   // field widths
   localparam int PIXEL_W     = 8;
   localparam int IMG_WIDTH_W = 6;
   localparam int IMG_HEIGHT_W = 8;
   localparam int KERNEL_W    = 3;
   localparam int PATCH_ROW_W = 8;
   localparam int PATCH_COL_W = 5;
   localparam int TAP_W       = 6;

   // stream and register port widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [IMG_WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 6'd28;
   localparam logic [IMG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 8'd28;
   localparam logic [KERNEL_W-1:0]     RST_KERNEL_HEIGHT = 3'd5;
   localparam logic [KERNEL_W-1:0]     RST_KERNEL_WIDTH  = 3'd5;

   // register index (byte address / 4)
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_KERNEL_HEIGHT = 2'd2,
      REG_KERNEL_WIDTH  = 2'd3
   } csr_index_type;

   // configuration as seen by the sequencer
   typedef struct packed {
      logic [IMG_WIDTH_W-1:0]  image_width;
      logic [IMG_HEIGHT_W-1:0] image_height;
      logic [KERNEL_W-1:0]     kernel_height;
      logic [KERNEL_W-1:0]     kernel_width;
   } cfg_type;

   // side information travelling with each line store read
   typedef struct packed {
      logic [PATCH_ROW_W-1:0] patch_row;
      logic [PATCH_COL_W-1:0] patch_col;
      logic [TAP_W-1:0]       tap;
      logic                   last_tap;
   } meta_type;

endpackage

@@ hw/rtl/swpe_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
module swpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 224
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port, read data holds when idle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/swpe_csr.sv @@
// configuration registers behind the apb-style port
module swpe_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [swpe_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [swpe_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [swpe_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output swpe_pkg::cfg_type               cfg,
   output logic                            cfg_wr
);
   import swpe_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   csr_index_type idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_IMAGE_WIDTH:   cfg_in.image_width   = csr_pwdata[IMG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_in.image_height  = csr_pwdata[IMG_HEIGHT_W-1:0];
            REG_KERNEL_HEIGHT: cfg_in.kernel_height = csr_pwdata[KERNEL_W-1:0];
            REG_KERNEL_WIDTH:  cfg_in.kernel_width  = csr_pwdata[KERNEL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= RST_IMAGE_WIDTH;
         cfg_ff.image_height  <= RST_IMAGE_HEIGHT;
         cfg_ff.kernel_height <= RST_KERNEL_HEIGHT;
         cfg_ff.kernel_width  <= RST_KERNEL_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.image_height);
         REG_KERNEL_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.kernel_height);
         REG_KERNEL_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.kernel_width);
      endcase
   end

   assign cfg    = cfg_ff;
   assign cfg_wr = wr_en;

endmodule

@@ hw/rtl/swpe_ctrl.sv @@
// position tracking, line store write, patch read sequencer and result stage
module swpe_ctrl #(
   parameter int MAX_WIDTH  = swpe_pkg::DEF_MAX_WIDTH,
   parameter int MAX_KERNEL = swpe_pkg::DEF_MAX_KERNEL,
   localparam int DEPTH     = MAX_KERNEL * MAX_WIDTH,
   localparam int AW        = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  swpe_pkg::cfg_type               cfg,
   input  logic                            cfg_wr,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swpe_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swpe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            ram_we,
   output logic [AW-1:0]                   ram_waddr,
   output logic [swpe_pkg::PIXEL_W-1:0]    ram_wdata,
   output logic                            ram_re,
   output logic [AW-1:0]                   ram_raddr,
   input  logic [swpe_pkg::PIXEL_W-1:0]    ram_rdata
);
   import swpe_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW    = ($clog2(MAX_WIDTH + 1) > IMG_WIDTH_W) ?
                          $clog2(MAX_WIDTH + 1) : IMG_WIDTH_W;

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   // control registers
   state_type                state_ff, state_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [IMG_HEIGHT_W-1:0]  row_ff, row_in;
   logic [AW-1:0]            base_ff, base_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic [AW-1:0]            rd_base_ff, rd_base_in;
   logic [COL_W-1:0]         rd_col_ff, rd_col_in;
   logic [COL_W-1:0]         left_ff, left_in;
   logic [PATCH_ROW_W-1:0]   top_ff, top_in;
   logic [KERNEL_W-1:0]      kx_ff, kx_in;
   logic [KERNEL_W-1:0]      ky_ff, ky_in;
   logic [KERNEL_W-1:0]      kw_m1_ff, kw_m1_in;
   logic [KERNEL_W-1:0]      kh_m1_ff, kh_m1_in;
   logic [TAP_W-1:0]         tap_ff, tap_in;
   meta_type                 pend_meta_ff, pend_meta_in;
   meta_type                 out_meta_ff, out_meta_in;
   logic [PIXEL_W-1:0]       out_value_ff, out_value_in;

   // combinational helpers
   logic [EW-1:0]            eff_w;
   logic [IMG_HEIGHT_W-1:0]  eff_h;
   logic [EW-1:0]            col_p1;
   logic [IMG_HEIGHT_W:0]    row_p1;
   logic                     col_last, row_last;
   logic                     kern_ok, patch_done, accept;
   logic [KERNEL_W-1:0]      kh_m1, kw_m1;
   logic [AW:0]              top_off, base_ext, next_base, rd_next_base;
   logic [AW-1:0]            top_base;
   logic                     out_free, pend_move, issue;
   logic                     kx_last, ky_last;
   meta_type                 issue_meta;

   // effective image size
   always_comb begin
      priority if (cfg.image_width == '0) begin
         eff_w = EW'(1);
      end else if (EW'(cfg.image_width) > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(cfg.image_width);
      end
      eff_h = (cfg.image_height == '0) ? IMG_HEIGHT_W'(1) : cfg.image_height;
   end

   // position and patch completion for the incoming pixel
   assign accept   = req_tvalid && req_tready;
   assign col_p1   = EW'(col_ff) + EW'(1);
   assign row_p1   = {1'b0, row_ff} + (IMG_HEIGHT_W+1)'(1);
   assign col_last = col_p1 >= eff_w;
   assign row_last = row_p1 >= {1'b0, eff_h};
   assign kh_m1    = cfg.kernel_height - KERNEL_W'(1);
   assign kw_m1    = cfg.kernel_width - KERNEL_W'(1);
   assign kern_ok  = (cfg.kernel_height != '0) && (cfg.kernel_width != '0) &&
                     ({1'b0, cfg.kernel_height} <= (KERNEL_W+1)'(MAX_KERNEL)) &&
                     ({1'b0, cfg.kernel_width} <= (KERNEL_W+1)'(MAX_KERNEL));
   assign patch_done = kern_ok &&
                       (row_p1 >= (IMG_HEIGHT_W+1)'(cfg.kernel_height)) &&
                       (col_p1 >= EW'(cfg.kernel_width));

   // line store row base of the patch's top row, one wrap at most
   assign base_ext  = {1'b0, base_ff};
   assign top_off   = (AW+1)'(kh_m1) * (AW+1)'(MAX_WIDTH);
   assign top_base  = (base_ext >= top_off) ? AW'(base_ext - top_off)
                                            : AW'(base_ext + (AW+1)'(DEPTH) - top_off);
   assign next_base = base_ext + (AW+1)'(MAX_WIDTH);
   assign rd_next_base = {1'b0, rd_base_ff} + (AW+1)'(MAX_WIDTH);

   // read issue against a two-stage result pipeline
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pend_move = pend_valid_ff && out_free;
   assign issue     = (state_ff == ST_EMIT) && (!pend_valid_ff || pend_move);
   assign kx_last   = kx_ff == kw_m1_ff;
   assign ky_last   = ky_ff == kh_m1_ff;

   always_comb begin
      issue_meta.patch_row = top_ff;
      issue_meta.patch_col = PATCH_COL_W'(left_ff);
      issue_meta.tap       = tap_ff;
      issue_meta.last_tap  = kx_last && ky_last;
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      rd_base_in   = rd_base_ff;
      rd_col_in    = rd_col_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      kx_in        = kx_ff;
      ky_in        = ky_ff;
      kw_m1_in     = kw_m1_ff;
      kh_m1_in     = kh_m1_ff;
      tap_in       = tap_ff;
      pend_valid_in = pend_valid_ff;
      pend_meta_in = pend_meta_ff;
      rsp_valid_in = rsp_valid_ff;
      out_meta_in  = out_meta_ff;
      out_value_in = out_value_ff;

      // raster position
      priority if (cfg_wr) begin
         col_in  = '0;
         row_in  = '0;
         base_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in  = row_p1[IMG_HEIGHT_W-1:0];
               base_in = (next_base >= (AW+1)'(DEPTH)) ? '0 : AW'(next_base);
            end
         end else begin
            col_in = col_p1[COL_W-1:0];
         end
      end else begin
         col_in = col_ff;
      end

      // start a patch
      if (accept && patch_done) begin
         state_in   = ST_EMIT;
         left_in    = COL_W'(col_p1 - EW'(cfg.kernel_width));
         top_in     = PATCH_ROW_W'(row_p1 - (IMG_HEIGHT_W+1)'(cfg.kernel_height));
         rd_col_in  = COL_W'(col_p1 - EW'(cfg.kernel_width));
         rd_base_in = top_base;
         kx_in      = '0;
         ky_in      = '0;
         kw_m1_in   = kw_m1;
         kh_m1_in   = kh_m1;
         tap_in     = '0;
      end

      // walk the taps, one read per cycle while the result stages have room
      if (issue) begin
         tap_in = tap_ff + TAP_W'(1);
         if (kx_last) begin
            kx_in     = '0;
            rd_col_in = left_ff;
            ky_in     = ky_ff + KERNEL_W'(1);
            rd_base_in = (rd_next_base >= (AW+1)'(DEPTH)) ? '0 : AW'(rd_next_base);
            if (ky_last) begin
               state_in = ST_IDLE;
            end
         end else begin
            kx_in     = kx_ff + KERNEL_W'(1);
            rd_col_in = rd_col_ff + COL_W'(1);
         end
      end

      // read in flight stage
      priority if (issue) begin
         pend_valid_in = 1'b1;
         pend_meta_in  = issue_meta;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end

      // output register
      priority if (pend_move) begin
         rsp_valid_in = 1'b1;
         out_meta_in  = pend_meta_ff;
         out_value_in = ram_rdata;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_base_ff   <= rd_base_in;
      rd_col_ff    <= rd_col_in;
      left_ff      <= left_in;
      top_ff       <= top_in;
      kx_ff        <= kx_in;
      ky_ff        <= ky_in;
      kw_m1_ff     <= kw_m1_in;
      kh_m1_ff     <= kh_m1_in;
      tap_ff       <= tap_in;
      pend_meta_ff <= pend_meta_in;
      out_meta_ff  <= out_meta_in;
      out_value_ff <= out_value_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // line store ports
   assign req_tready = state_ff == ST_IDLE;
   assign ram_we     = accept;
   assign ram_waddr  = base_ff + AW'(col_ff);
   assign ram_wdata  = req_tdata[PIXEL_W-1:0];
   assign ram_re     = issue;
   assign ram_raddr  = rd_base_ff + AW'(rd_col_ff);

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_meta_ff.last_tap;
   assign rsp_tdata  = {5'd0, out_meta_ff.tap, out_meta_ff.patch_col,
                        out_meta_ff.patch_row, out_value_ff};

endmodule

@@ hw/rtl/sliding_window_patch_extractor_unit.sv @@
// top level of the sliding-window patch extractor
//
//  channel  direction  handshake               payload
//  req_     in         req_tvalid/req_tready   pixel
//  rsp_     out        rsp_tvalid/rsp_tready   value, patch_row, patch_col, tap; tlast = last_tap
//  csr_     in         psel/penable/pready     image_width, image_height, kernel_height/width
//
//  a pixel that completes no patch is only written; one that completes a patch then reads its
//  kernel_height*kernel_width taps, one tap per cycle off the single line store read port
//  taps leave through a read stage and an output register, so input is taken again
//  while the last taps still drain
//  rsp_tready low stalls the tap walk; no result is dropped
//  reset is synchronous, active high; the line store needs no clearing pass
module sliding_window_patch_extractor_unit #(
   parameter int MAX_WIDTH  = swpe_pkg::DEF_MAX_WIDTH,
   parameter int MAX_KERNEL = swpe_pkg::DEF_MAX_KERNEL
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swpe_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] value, [15:8] patch_row, [20:16] patch_col, [26:21] tap, [31:27] zero
   output logic [swpe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [swpe_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [swpe_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [swpe_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import swpe_pkg::*;

   localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   cfg_type            cfg;
   logic               cfg_wr;
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [PIXEL_W-1:0] ram_wdata, ram_rdata;

   // configuration registers
   swpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   // line store, MAX_KERNEL rows by MAX_WIDTH pixels
   swpe_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer and result stage
   swpe_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_wr     (cfg_wr),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

`ifndef SYNTHESIS
   // pixel writes and tap reads never share a cycle
   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("line store written and read in the same cycle");

   // write address stays inside the line store
   a_waddr_range : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((AW+1)'(ram_waddr) < (AW+1)'(DEPTH)))
      else $error("line store write address out of range");

   // read address stays inside the line store
   a_raddr_range : assert property (@(posedge clock) disable iff (reset)
      ram_re |-> ((AW+1)'(ram_raddr) < (AW+1)'(DEPTH)))
      else $error("line store read address out of range");

   // no new pixel is taken while taps of a patch are still being read
   a_no_accept_in_walk : assert property (@(posedge clock) disable iff (reset)
      ram_re |-> !req_tready)
      else $error("pixel taken during a patch walk");
`endif

endmodule
